### rtl/ggvc_pkg.sv
// ggvc_pkg: types, constants and the arctangent table of the go-to-goal controller.
// Shared by the controller, the datapath, the CORDIC unit and the top level.
// No dependencies.
package ggvc_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TICK_BITS    = 13;
    // iterations actually run; the arctangent table holds 32 entries
    localparam int STEPS_USED   = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    // step counter wide enough for any step count up to the table size
    localparam int STEP_CNT_W   = $clog2(32 + 1);

    localparam int XW = 36;     // CORDIC x/y width
    localparam int ZW = 35;     // Q30 angle width
    localparam int PW = XW + 17; // shared multiplier product width

    localparam logic signed [ZW-1:0] PI_Q30      = ZW'(64'sd3373259426);
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(64'sd1686629713);
    localparam logic signed [ZW-1:0] TWO_PI_Q30  = ZW'(64'sd6746518852);
    localparam logic signed [15:0]   PI_Q13      = 16'sd25736;
    localparam logic signed [16:0]   TWO_PI_Q13  = 17'sd51472;
    localparam logic signed [16:0]   INV_GAIN    = 17'sd39797;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_POSE = 2'd1,
        KIND_GOAL = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        MODE_NO_GOAL   = 3'd0,
        MODE_REACHED   = 3'd1,
        MODE_ROTATE    = 3'd2,
        MODE_TRANSLATE = 3'd3,
        MODE_STEER     = 3'd4,
        MODE_STALE     = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        CFG_DIST_TH   = 3'd0,
        CFG_ANGLE_TH  = 3'd1,
        CFG_SCALE     = 3'd2,
        CFG_MAX_LIN   = 3'd3,
        CFG_MAX_TURN  = 3'd4,
        CFG_TIMEOUT   = 3'd5
    } t_cfg_idx;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,      // capture input transaction
        OP_TICK,      // age watchdog
        OP_POSE,      // clear watchdog
        OP_VEC_BRG,   // start vectoring on goal - pose
        OP_BRG_SAVE,
        OP_MAG_MUL,
        OP_DIST,
        OP_QM0,       // quaternion products, one per cycle
        OP_QM1,
        OP_QM2,
        OP_QM3,
        OP_QEND,
        OP_VEC_YAW,
        OP_YAW_SAVE,
        OP_GOAL_SAVE,
        OP_ERR,
        OP_SCL_MUL,
        OP_SQ_START,
        OP_SPD,
        OP_V_MUL,
        OP_BODY,
        OP_ROT,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op   op;
        t_mode mode;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       tick_expire;
        logic       pose_recent;
        logic       goal_valid;
        logic       cordic_busy;
        logic       sqrt_busy;
        logic       near;
        logic       aligned;
        logic       out_busy;
    } t_status;

    // atan(2^-i) in Q30
    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

### rtl/ggvc_cordic.sv
// ggvc_cordic: iterative CORDIC, vectoring or rotation, one step per cycle.
// Depends on ggvc_pkg.
module ggvc_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_rotate,
    input  logic signed [ggvc_pkg::XW-1:0]    i_x,
    input  logic signed [ggvc_pkg::XW-1:0]    i_y,
    input  logic signed [ggvc_pkg::ZW-1:0]    i_z,
    output logic                              o_busy,
    output logic signed [ggvc_pkg::XW-1:0]    o_x,
    output logic signed [ggvc_pkg::XW-1:0]    o_y,
    output logic signed [ggvc_pkg::ZW-1:0]    o_z
);
    import ggvc_pkg::*;

    logic signed [XW-1:0] r_x, r_y, n_x, n_y, xs, ys;
    logic signed [ZW-1:0] r_z, n_z, atan_z;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic r_busy, r_rot, cw;

    assign xs     = r_x >>> r_cnt[4:0];
    assign ys     = r_y >>> r_cnt[4:0];
    assign atan_z = $signed({{(ZW-32){1'b0}}, atan_q30(r_cnt[4:0])});
    // clockwise micro-rotation: x += y/2^i, y -= x/2^i, z += atan
    assign cw     = r_rot ? r_z[ZW-1] : (!r_y[XW-1] && (r_y != '0));

    always_comb begin
        if (cw) begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + atan_z;
        end else begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - atan_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_cnt <= '0;
            r_rot <= i_rotate;
            if (i_rotate) begin
                r_busy <= 1'b1;
                r_x <= i_x;
                r_y <= i_y;
                r_z <= i_z;
            end else if (i_x == '0 && i_y == '0) begin
                // zero vector: angle and magnitude zero, nothing to iterate
                r_busy <= 1'b0;
                r_x <= '0;
                r_y <= '0;
                r_z <= '0;
            end else begin
                r_busy <= 1'b1;
                if (!i_x[XW-1]) begin
                    r_x <= i_x;
                    r_y <= i_y;
                    r_z <= '0;
                end else if (!i_y[XW-1]) begin
                    r_x <= i_y;
                    r_y <= -i_x;
                    r_z <= HALF_PI_Q30;
                end else begin
                    r_x <= -i_y;
                    r_y <= i_x;
                    r_z <= -HALF_PI_Q30;
                end
            end
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == STEP_CNT_W'(STEPS_USED - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

### rtl/ggvc_dp.sv
// ggvc_dp: datapath of the go-to-goal controller: operand and state registers,
// shared multiplier, square root loop, config registers and output register.
// Depends on ggvc_pkg and ggvc_cordic.
module ggvc_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ggvc_pkg::t_cmd       i_cmd,
    output ggvc_pkg::t_status    o_status,
    input  logic [127:0]         i_s_tdata,
    input  logic [1:0]           i_s_tuser,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [47:0]          o_m_tdata,
    output logic [2:0]           o_m_tuser
);
    import ggvc_pkg::*;

    function automatic logic signed [15:0] q30_to_q13(input logic signed [ZW-1:0] a);
        logic signed [ZW-1:0] t;
        t = (a + ZW'(65536)) >>> 17;
        if (t > ZW'(PI_Q13)) begin
            t = ZW'(PI_Q13);
        end else if (t < -ZW'(PI_Q13)) begin
            t = -ZW'(PI_Q13);
        end
        return 16'(t);
    endfunction

    function automatic logic signed [15:0] round_q12(input logic signed [XW-1:0] v,
                                                     input logic flip);
        logic signed [XW-1:0] t;
        t = (v + XW'(32768)) >>> 16;
        if (flip) begin
            t = -t;
        end
        if (t > XW'(32767)) begin
            t = XW'(32767);
        end else if (t < -XW'(32768)) begin
            t = -XW'(32768);
        end
        return 16'(t);
    endfunction

    // input operands
    logic [1:0]         r_kind;
    logic signed [31:0] r_px, r_py;
    logic signed [15:0] r_qx, r_qy, r_qz, r_qw;
    // config
    logic [30:0] r_dist_th;
    logic [14:0] r_ang_th, r_max_lin, r_max_turn;
    logic [15:0] r_scale;
    logic [12:0] r_timeout;
    // persistent state
    logic signed [31:0] r_goal_x, r_goal_y;
    logic signed [15:0] r_goal_hd;
    logic               r_goal_valid, r_pose_recent;
    logic [TICK_BITS-1:0] r_ticks, tick_inc;
    // work registers
    logic signed [PW-1:0] r_prod, mul_p;
    logic signed [XW-1:0] mul_a, r_num, r_den, r_mag;
    logic signed [16:0]   mul_b;
    logic signed [ZW-1:0] r_bearing, r_yaw, r_body, body_d, rot_z;
    logic [33:0]          r_dist;
    logic signed [16:0]   r_err, err_d, turn_t, max_turn_s;
    logic signed [15:0]   yaw13;
    logic [14:0]          r_speed;
    logic                 r_flip, rot_flip;
    logic [42:0]          r_sq_n, r_sq_r, r_sq_b, sq_sum;
    // CORDIC
    logic                 c_start, c_rotate, c_busy;
    logic signed [XW-1:0] c_xi, c_yi, c_x, c_y;
    logic signed [ZW-1:0] c_zi, c_z;
    // output
    logic                 r_out_valid;
    logic signed [15:0]   r_vx, r_vy, r_turn, turn_v;
    t_mode                r_mode;
    logic                 tick_expire;

    // ---- multiplier operands ----
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            OP_QM0: begin mul_a = XW'(r_qw); mul_b = 17'(r_qz); end
            OP_QM1: begin mul_a = XW'(r_qx); mul_b = 17'(r_qy); end
            OP_QM2: begin mul_a = XW'(r_qy); mul_b = 17'(r_qy); end
            OP_QM3: begin mul_a = XW'(r_qz); mul_b = 17'(r_qz); end
            OP_MAG_MUL: begin mul_a = r_mag; mul_b = INV_GAIN; end
            OP_SCL_MUL: begin
                mul_a = $signed({2'b00, r_dist});
                mul_b = $signed({1'b0, r_scale});
            end
            OP_V_MUL: begin
                mul_a = $signed({{(XW-15){1'b0}}, r_speed});
                mul_b = INV_GAIN;
            end
            default: begin end
        endcase
    end
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // ---- CORDIC operands ----
    always_comb begin
        rot_flip = 1'b0;
        rot_z    = r_body;
        if (r_body > HALF_PI_Q30) begin
            rot_z = r_body - PI_Q30;
            rot_flip = 1'b1;
        end else if (r_body < -HALF_PI_Q30) begin
            rot_z = r_body + PI_Q30;
            rot_flip = 1'b1;
        end
    end

    always_comb begin
        c_start  = 1'b0;
        c_rotate = 1'b0;
        c_xi     = '0;
        c_yi     = '0;
        c_zi     = '0;
        unique case (i_cmd.op)
            OP_VEC_BRG: begin
                c_start = 1'b1;
                c_xi = XW'(r_goal_x) - XW'(r_px);
                c_yi = XW'(r_goal_y) - XW'(r_py);
            end
            OP_VEC_YAW: begin
                c_start = 1'b1;
                c_xi = XW'(64'sd268435456) - (r_den <<< 1);
                c_yi = r_num <<< 1;
            end
            OP_ROT: begin
                c_start  = 1'b1;
                c_rotate = 1'b1;
                c_xi = r_prod[XW-1:0];
                c_zi = rot_z;
            end
            default: begin end
        endcase
    end

    ggvc_cordic u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (c_start),
        .i_rotate (c_rotate),
        .i_x      (c_xi),
        .i_y      (c_yi),
        .i_z      (c_zi),
        .o_busy   (c_busy),
        .o_x      (c_x),
        .o_y      (c_y),
        .o_z      (c_z)
    );

    // ---- small combinational pieces ----
    assign tick_inc    = (r_ticks != {TICK_BITS{1'b1}}) ? r_ticks + 1'b1 : r_ticks;
    assign tick_expire = 32'(tick_inc) > 32'(r_timeout);
    assign yaw13       = q30_to_q13(r_yaw);
    assign sq_sum      = r_sq_r + r_sq_b;

    always_comb begin
        err_d = 17'(r_goal_hd) - 17'(yaw13);
        if (err_d > 17'(PI_Q13)) begin
            err_d = err_d - TWO_PI_Q13;
        end else if (err_d < -17'(PI_Q13)) begin
            err_d = err_d + TWO_PI_Q13;
        end
    end

    always_comb begin
        body_d = r_bearing - r_yaw;
        if (body_d > PI_Q30) begin
            body_d = body_d - TWO_PI_Q30;
        end else if (body_d < -PI_Q30) begin
            body_d = body_d + TWO_PI_Q30;
        end
    end

    assign max_turn_s = $signed({2'b00, r_max_turn});
    always_comb begin
        turn_t = (r_err + 17'sd1) >>> 1;
        if (turn_t > max_turn_s) begin
            turn_t = max_turn_s;
        end else if (turn_t < -max_turn_s) begin
            turn_t = -max_turn_s;
        end
        turn_v = 16'(turn_t);
    end

    // ---- config registers ----
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_th  <= 31'd131072;
            r_ang_th   <= 15'd1430;
            r_scale    <= 16'd3277;
            r_max_lin  <= 15'd2048;
            r_max_turn <= 15'd2048;
            r_timeout  <= 13'd6000;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DIST_TH:  r_dist_th  <= i_cfg_data[30:0];
                CFG_ANGLE_TH: r_ang_th   <= i_cfg_data[14:0];
                CFG_SCALE:    r_scale    <= i_cfg_data[15:0];
                CFG_MAX_LIN:  r_max_lin  <= i_cfg_data[14:0];
                CFG_MAX_TURN: r_max_turn <= i_cfg_data[14:0];
                CFG_TIMEOUT:  r_timeout  <= i_cfg_data[12:0];
                default: begin end
            endcase
        end
    end

    // ---- persistent state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x      <= '0;
            r_goal_y      <= '0;
            r_goal_hd     <= '0;
            r_goal_valid  <= 1'b0;
            r_pose_recent <= 1'b0;
            r_ticks       <= {TICK_BITS{1'b1}};
        end else begin
            unique case (i_cmd.op)
                OP_TICK: begin
                    r_ticks       <= tick_inc;
                    r_pose_recent <= !tick_expire;
                end
                OP_POSE: r_ticks <= '0;
                OP_GOAL_SAVE: begin
                    r_goal_x     <= r_px;
                    r_goal_y     <= r_py;
                    r_goal_hd    <= q30_to_q13(c_z);
                    r_goal_valid <= 1'b1;
                end
                default: begin end
            endcase
        end
    end

    // ---- work registers ----
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_kind <= i_s_tuser;
            r_px   <= i_s_tdata[31:0];
            r_py   <= i_s_tdata[63:32];
            r_qx   <= i_s_tdata[79:64];
            r_qy   <= i_s_tdata[95:80];
            r_qz   <= i_s_tdata[111:96];
            r_qw   <= i_s_tdata[127:112];
        end
        if (i_cmd.op == OP_QM0 || i_cmd.op == OP_QM1 || i_cmd.op == OP_QM2 ||
            i_cmd.op == OP_QM3 || i_cmd.op == OP_MAG_MUL || i_cmd.op == OP_SCL_MUL ||
            i_cmd.op == OP_V_MUL) begin
            r_prod <= mul_p;
        end
        unique case (i_cmd.op)
            OP_QM1:      r_num <= r_prod[XW-1:0];
            OP_QM2:      r_num <= r_num + r_prod[XW-1:0];
            OP_QM3:      r_den <= r_prod[XW-1:0];
            OP_QEND:     r_den <= r_den + r_prod[XW-1:0];
            OP_BRG_SAVE: begin
                r_bearing <= c_z;
                r_mag     <= c_x[XW-1] ? '0 : c_x;
            end
            OP_DIST:     r_dist  <= r_prod[49:16];
            OP_YAW_SAVE: r_yaw   <= c_z;
            OP_ERR:      r_err   <= err_d;
            OP_SPD:      r_speed <= (r_sq_r > 43'(r_max_lin)) ? r_max_lin : r_sq_r[14:0];
            OP_BODY:     r_body  <= body_d;
            OP_ROT:      r_flip  <= rot_flip;
            default: begin end
        endcase
    end

    // ---- square root, one result bit per cycle ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_b <= '0;
        end else if (i_cmd.op == OP_SQ_START) begin
            r_sq_n <= {1'b0, r_prod[49:8]};
            r_sq_r <= '0;
            r_sq_b <= 43'(1) << 42;
        end else if (r_sq_b != '0) begin
            if (r_sq_n >= sq_sum) begin
                r_sq_n <= r_sq_n - sq_sum;
                r_sq_r <= (r_sq_r >> 1) + r_sq_b;
            end else begin
                r_sq_r <= r_sq_r >> 1;
            end
            r_sq_b <= r_sq_b >> 2;
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT) begin
            r_mode <= i_cmd.mode;
            if (i_cmd.mode == MODE_TRANSLATE || i_cmd.mode == MODE_STEER) begin
                r_vx <= round_q12(c_x, r_flip);
                r_vy <= round_q12(c_y, r_flip);
            end else begin
                r_vx <= '0;
                r_vy <= '0;
            end
            if (i_cmd.mode == MODE_ROTATE || i_cmd.mode == MODE_STEER) begin
                r_turn <= turn_v;
            end else begin
                r_turn <= '0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_turn, r_vy, r_vx};
    assign o_m_tuser  = r_mode;

    // ---- status ----
    assign o_status.kind        = r_kind;
    assign o_status.tick_expire = tick_expire;
    assign o_status.pose_recent = r_pose_recent;
    assign o_status.goal_valid  = r_goal_valid;
    assign o_status.cordic_busy = c_busy;
    assign o_status.sqrt_busy   = (r_sq_b != '0);
    assign o_status.near        = r_dist < {3'b000, r_dist_th};
    assign o_status.aligned     = (r_err[16] ? -r_err : r_err) < $signed({2'b00, r_ang_th});
    assign o_status.out_busy    = r_out_valid && !i_m_tready;

endmodule

### rtl/ggvc_ctrl.sv
// ggvc_ctrl: sequencer of the go-to-goal controller; issues one datapath
// command per cycle. Depends on ggvc_pkg.
module ggvc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  ggvc_pkg::t_status    i_status,
    output ggvc_pkg::t_cmd       o_cmd
);
    import ggvc_pkg::*;

    typedef enum logic [27:0] {
        S_IDLE = 28'h0000001,
        S_DISP = 28'h0000002,
        S_TICK = 28'h0000004,
        S_POSE = 28'h0000008,
        S_VB   = 28'h0000010,
        S_VBW  = 28'h0000020,
        S_BSV  = 28'h0000040,
        S_MM   = 28'h0000080,
        S_DST  = 28'h0000100,
        S_Q0   = 28'h0000200,
        S_Q1   = 28'h0000400,
        S_Q2   = 28'h0000800,
        S_Q3   = 28'h0001000,
        S_Q4   = 28'h0002000,
        S_VY   = 28'h0004000,
        S_VYW  = 28'h0008000,
        S_YSV  = 28'h0010000,
        S_ERR  = 28'h0020000,
        S_DEC  = 28'h0040000,
        S_SM   = 28'h0080000,
        S_SQS  = 28'h0100000,
        S_SQW  = 28'h0200000,
        S_SPD  = 28'h0400000,
        S_VM   = 28'h0800000,
        S_BODY = 28'h1000000,
        S_ROT  = 28'h2000000,
        S_RW   = 28'h4000000,
        S_EMIT = 28'h8000000
    } t_state;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic   r_is_goal, n_is_goal;
    t_op    op;

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_is_goal = r_is_goal;
        op        = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    op = OP_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_is_goal = 1'b0;
                case (t_kind'(i_status.kind))
                    KIND_TICK: n_state = S_TICK;
                    KIND_POSE: n_state = S_POSE;
                    KIND_GOAL: begin
                        n_is_goal = 1'b1;
                        n_state = S_Q0;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_TICK: begin
                op = OP_TICK;
                if (i_status.tick_expire) begin
                    n_mode = MODE_STALE;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_POSE: begin
                op = OP_POSE;
                if (!i_status.pose_recent) begin
                    n_mode = MODE_STALE;
                    n_state = S_EMIT;
                end else if (!i_status.goal_valid) begin
                    n_mode = MODE_NO_GOAL;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_VB;
                end
            end
            S_VB: begin op = OP_VEC_BRG; n_state = S_VBW; end
            S_VBW: if (!i_status.cordic_busy) n_state = S_BSV;
            S_BSV: begin op = OP_BRG_SAVE; n_state = S_MM; end
            S_MM:  begin op = OP_MAG_MUL;  n_state = S_DST; end
            S_DST: begin op = OP_DIST;     n_state = S_Q0; end
            S_Q0:  begin op = OP_QM0;      n_state = S_Q1; end
            S_Q1:  begin op = OP_QM1;      n_state = S_Q2; end
            S_Q2:  begin op = OP_QM2;      n_state = S_Q3; end
            S_Q3:  begin op = OP_QM3;      n_state = S_Q4; end
            S_Q4:  begin op = OP_QEND;     n_state = S_VY; end
            S_VY:  begin op = OP_VEC_YAW;  n_state = S_VYW; end
            S_VYW: if (!i_status.cordic_busy) n_state = S_YSV;
            S_YSV: begin
                if (r_is_goal) begin
                    op = OP_GOAL_SAVE;
                    n_state = S_IDLE;
                end else begin
                    op = OP_YAW_SAVE;
                    n_state = S_ERR;
                end
            end
            S_ERR: begin op = OP_ERR; n_state = S_DEC; end
            S_DEC: begin
                if (i_status.near && i_status.aligned) begin
                    n_mode = MODE_REACHED;
                    n_state = S_EMIT;
                end else if (i_status.near) begin
                    n_mode = MODE_ROTATE;
                    n_state = S_EMIT;
                end else begin
                    n_mode = i_status.aligned ? MODE_TRANSLATE : MODE_STEER;
                    n_state = S_SM;
                end
            end
            S_SM:   begin op = OP_SCL_MUL;  n_state = S_SQS; end
            S_SQS:  begin op = OP_SQ_START; n_state = S_SQW; end
            S_SQW:  if (!i_status.sqrt_busy) n_state = S_SPD;
            S_SPD:  begin op = OP_SPD;   n_state = S_VM; end
            S_VM:   begin op = OP_V_MUL; n_state = S_BODY; end
            S_BODY: begin op = OP_BODY;  n_state = S_ROT; end
            S_ROT:  begin op = OP_ROT;   n_state = S_RW; end
            S_RW:   if (!i_status.cordic_busy) n_state = S_EMIT;
            S_EMIT: begin
                if (!i_status.out_busy) begin
                    op = OP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= MODE_NO_GOAL;
            r_is_goal <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_is_goal <= n_is_goal;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_cmd.op   = op;
    assign o_cmd.mode = r_mode;

endmodule

### rtl/go_to_goal_velocity_controller.sv
// Go-to-goal velocity controller, top level: sequencer plus datapath.
// Work: tick or stop pose uses no iterative unit; goal runs one 16-step CORDIC
//   vectoring pass; pose at goal two; full pose two, 22-step square root, 16-step rotation.
// Throughput: one transaction at a time; the next is taken when the sequencer is idle.
// Reset: synchronous active-low i_rst_n restores register defaults, clears the goal,
//   sets the pose watchdog to timed out and drops the output valid.
module go_to_goal_velocity_controller (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,  // pos_x[31:0] pos_y[63:32] quat_x[79:64]
                                     // quat_y[95:80] quat_z[111:96] quat_w[127:112]
    input  logic [1:0]   i_s_tuser,  // cmd: 0 tick, 1 pose, 2 goal
    // result stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [47:0]  o_m_tdata,  // vel_x[15:0] vel_y[31:16] turn_rate[47:32]
    output logic [2:0]   o_m_tuser,  // mode
    // register write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import ggvc_pkg::*;

    t_cmd    w_cmd;
    t_status w_st;

    // sequencer: walks the command list for each transaction kind
    ggvc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_st),
        .o_cmd      (w_cmd)
    );

    // datapath: holds goal, watchdog, config and all arithmetic
    ggvc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_st),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

`ifndef ASSERT_OFF
    // a new transaction never lands while an iterative unit is still running
    a_accept_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |-> (!w_st.cordic_busy && !w_st.sqrt_busy))
        else $error("transaction accepted while CORDIC or sqrt busy");

    // a result is only written into a free output slot
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_EMIT) |-> !(o_m_tvalid && !i_m_tready))
        else $error("result overwrote a pending output");

    // stop-type modes carry zero velocities
    a_zero_modes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == MODE_NO_GOAL || o_m_tuser == MODE_REACHED ||
                        o_m_tuser == MODE_STALE)) |-> (o_m_tdata == '0))
        else $error("nonzero velocity in a stop mode");
`endif

endmodule

### sim/go_to_goal_velocity_controller_tb.sv
// Self-checking testbench for go_to_goal_velocity_controller.
// Drives ticks, poses and goals through the input stream, predicts each command with its
// own fixed-point model and checks the result stream. Depends on rtl/ggvc_pkg.sv and the top level.
`timescale 1ns / 100ps

module go_to_goal_velocity_controller_tb;
    import ggvc_pkg::*;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_valid;
    logic         o_s_tready;
    logic [127:0] s_data;
    logic [1:0]   s_user;
    logic         o_m_tvalid;
    logic         m_ready;
    logic [47:0]  o_m_tdata;
    logic [2:0]   o_m_tuser;
    logic         cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    go_to_goal_velocity_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_data),
        .i_s_tuser   (s_user),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // one input transaction
    typedef struct {
        logic [1:0]  kind;
        logic [31:0] px, py;
        logic [15:0] qx, qy, qz, qw;
    } item_t;

    // one expected velocity command
    typedef struct {
        logic [15:0] vx, vy, turn;
        logic [2:0]  mode;
    } cmd_t;

    item_t pending_items[$];
    cmd_t  expected_cmds[$];
    int    errors;
    int    send_idle_pct, recv_stall_pct;
    int    hold_req, hold_done, hold_left;

    // fixed-point constants of the controller
    localparam longint PI30      = 64'sd3373259426;
    localparam longint HALF_PI30 = 64'sd1686629713;
    localparam longint TWO_PI30  = 64'sd6746518852;
    localparam longint PI13      = 64'sd25736;
    localparam longint TWO_PI13  = 64'sd51472;
    localparam longint INV_K     = 64'sd39797;
    localparam longint TICK_MAX  = 64'sd8191;

    longint arctan_q30 [16] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
        64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
    };

    // mirrored register file and controller state
    longint dist_th, angle_th, scale, max_lin, max_turn, timeout;
    longint goal_x, goal_y, goal_hdg, ticks_since;
    bit     goal_set, pose_fresh;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // CORDIC vectoring: returns atan2(yi, xi) in Q30, gain-scaled magnitude in mag
    function automatic longint atan2_q30(input longint xi, input longint yi,
                                         output longint mag);
        longint x, y, z, t, xs, ys;
        x = xi; y = yi; z = 0;
        if (x == 0 && y == 0) begin
            mag = 0;
            return 0;
        end
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = HALF_PI30;
            end else begin
                x = -y; y = t; z = -HALF_PI30;
            end
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys; y -= xs; z += arctan_q30[i];
            end else begin
                x -= ys; y += xs; z -= arctan_q30[i];
            end
        end
        mag = x < 0 ? 0 : x;
        return z;
    endfunction

    function automatic longint yaw_q30(input item_t it);
        longint qx, qy, qz, qw, num, den, m;
        qx = longint'($signed(it.qx)); qy = longint'($signed(it.qy));
        qz = longint'($signed(it.qz)); qw = longint'($signed(it.qw));
        num = 2 * (qw * qz + qx * qy);
        den = (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz);
        return atan2_q30(den, num, m);
    endfunction

    function automatic longint to_q13(input longint a);
        return clip((a + 65536) >>> 17, -PI13, PI13);
    endfunction

    // speed (Q4.12) resolved along body angle z (Q30), CORDIC rotation
    function automatic void body_vel(input longint v, input longint zi,
                                     output longint c, output longint s);
        longint x, y, z, xs, ys;
        bit flip;
        z = zi; flip = 0;
        if (z > HALF_PI30) begin
            z -= PI30; flip = 1;
        end else if (z < -HALF_PI30) begin
            z += PI30; flip = 1;
        end
        x = v * INV_K;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= arctan_q30[i];
            end else begin
                x += ys; y -= xs; z += arctan_q30[i];
            end
        end
        x = (x + 32768) >>> 16;
        y = (y + 32768) >>> 16;
        if (flip) begin
            x = -x; y = -y;
        end
        c = clip(x, -32768, 32767);
        s = clip(y, -32768, 32767);
    endfunction

    function automatic longint int_sqrt(input longint n_in);
        longint n, r, b;
        n = n_in; r = 0; b = 64'sd1 <<< 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void push_cmd(input longint vx, input longint vy, input longint w,
                                     input t_mode m);
        cmd_t c;
        c.vx = vx[15:0]; c.vy = vy[15:0]; c.turn = w[15:0]; c.mode = m;
        expected_cmds.push_back(c);
    endfunction

    // updates the mirrored state for one accepted transaction, queues its command if any
    task automatic predict_command(input item_t it);
        longint px, py, mag, brg, yaw, err, turn, body, vx, vy, gap, speed;
        bit near, aligned;
        px = longint'($signed(it.px));
        py = longint'($signed(it.py));
        case (it.kind)
            KIND_TICK: begin
                if (ticks_since < TICK_MAX) ticks_since++;
                if (ticks_since > timeout) begin
                    pose_fresh = 0;
                    push_cmd(0, 0, 0, MODE_STALE);
                end else begin
                    pose_fresh = 1;
                end
            end
            KIND_GOAL: begin
                goal_x = px; goal_y = py;
                goal_hdg = to_q13(yaw_q30(it));
                goal_set = 1;
            end
            KIND_POSE: begin
                ticks_since = 0;
                if (!pose_fresh) begin
                    push_cmd(0, 0, 0, MODE_STALE);
                end else if (!goal_set) begin
                    push_cmd(0, 0, 0, MODE_NO_GOAL);
                end else begin
                    brg = atan2_q30(goal_x - px, goal_y - py, mag);
                    gap = (mag * INV_K) >> 16;
                    yaw = yaw_q30(it);
                    err = goal_hdg - to_q13(yaw);
                    if (err > PI13) err -= TWO_PI13;
                    else if (err < -PI13) err += TWO_PI13;
                    near = gap < dist_th;
                    aligned = (err < 0 ? -err : err) < angle_th;
                    turn = clip((err + 1) >>> 1, -max_turn, max_turn);
                    if (near && aligned) begin
                        push_cmd(0, 0, 0, MODE_REACHED);
                    end else if (near) begin
                        push_cmd(0, 0, turn, MODE_ROTATE);
                    end else begin
                        speed = int_sqrt((scale * gap) >> 8);
                        if (speed > max_lin) speed = max_lin;
                        body = brg - yaw;
                        if (body > PI30) body -= TWO_PI30;
                        else if (body < -PI30) body += TWO_PI30;
                        body_vel(speed, body, vx, vy);
                        if (aligned) push_cmd(vx, vy, 0, MODE_TRANSLATE);
                        else push_cmd(vx, vy, turn, MODE_STEER);
                    end
                end
            end
            default: ; // unused kind, ignored
        endcase
    endtask

    // clock: 12 ns period
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // input driver: retires accepted transactions into the predictor, then offers the next
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_tready) predict_command('{s_user, s_data[31:0], s_data[63:32],
                s_data[79:64], s_data[95:80], s_data[111:96], s_data[127:112]});
            if (!s_valid || o_s_tready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    item_t it;
                    it = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_user  <= it.kind;
                    s_data  <= {it.qw, it.qz, it.qy, it.qx, it.py, it.px};
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver: random stalls plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_done != hold_req) begin
            hold_done <= hold_done + 1;
            hold_left <= 600;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: each result transaction against the oldest expected command
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && m_ready) begin
            if (expected_cmds.size() == 0) begin
                $error("result with nothing expected: tdata %h tuser %0d", o_m_tdata, o_m_tuser);
                errors++;
            end else begin
                cmd_t c;
                c = expected_cmds.pop_front();
                if (o_m_tdata[15:0] !== c.vx) begin
                    $error("vel_x expected %0d got %0d", $signed(c.vx), $signed(o_m_tdata[15:0]));
                    errors++;
                end
                if (o_m_tdata[31:16] !== c.vy) begin
                    $error("vel_y expected %0d got %0d", $signed(c.vy), $signed(o_m_tdata[31:16]));
                    errors++;
                end
                if (o_m_tdata[47:32] !== c.turn) begin
                    $error("turn_rate expected %0d got %0d", $signed(c.turn),
                           $signed(o_m_tdata[47:32]));
                    errors++;
                end
                if (o_m_tuser !== c.mode) begin
                    $error("mode expected %0d got %0d", c.mode, o_m_tuser);
                    errors++;
                end
            end
        end
    end

    // register write; only called while the block is idle
    task automatic write_reg(input t_cfg_idx idx, input longint val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[31:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DIST_TH:  dist_th  = val & 64'h7FFFFFFF;
            CFG_ANGLE_TH: angle_th = val & 64'h7FFF;
            CFG_SCALE:    scale    = val & 64'hFFFF;
            CFG_MAX_LIN:  max_lin  = val & 64'h7FFF;
            CFG_MAX_TURN: max_turn = val & 64'h7FFF;
            default:      timeout  = val & 64'h1FFF;
        endcase
    endtask

    // waits until every transaction is sent and every command seen, then for the slowest pose
    task automatic drain();
        while (pending_items.size() > 0 || s_valid || expected_cmds.size() > 0)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    function automatic item_t mk(input logic [1:0] k, input longint x, input longint y,
                                 input longint qz, input longint qw);
        item_t it;
        it.kind = k; it.px = x[31:0]; it.py = y[31:0];
        it.qx = 16'd0; it.qy = 16'd0; it.qz = qz[15:0]; it.qw = qw[15:0];
        return it;
    endfunction

    longint last_gx, last_gy;

    // random transaction; mostly ticks and poses around the current goal
    function automatic item_t rand_item();
        item_t it;
        int r, sel;
        longint span;
        r = $urandom_range(99);
        sel = $urandom_range(3);
        span = sel == 0 ? 64'sd4096 : (sel == 1 ? 64'sd200000 : 64'sd4000000);
        it.kind = r < 38 ? KIND_POSE : (r < 80 ? KIND_TICK : (r < 92 ? KIND_GOAL : 2'd3));
        if (r >= 96) begin
            // raw noise on every field
            it.px = $urandom; it.py = $urandom;
            it.qx = $urandom; it.qy = $urandom; it.qz = $urandom; it.qw = $urandom;
            it.kind = $urandom_range(2);
        end else begin
            it.px = 32'(last_gx + longint'($urandom_range(2 * span)) - span);
            it.py = 32'(last_gy + longint'($urandom_range(2 * span)) - span);
            it.qx = 16'($signed($urandom_range(256)) - 128);
            it.qy = 16'($signed($urandom_range(256)) - 128);
            it.qz = 16'($signed($urandom_range(32768)) - 16384);
            it.qw = 16'($signed($urandom_range(32768)) - 16384);
        end
        if (it.kind == KIND_GOAL) begin
            if ($urandom_range(9) == 0) begin
                it.px = $urandom; it.py = $urandom;
            end
            last_gx = longint'($signed(it.px));
            last_gy = longint'($signed(it.py));
        end
        return it;
    endfunction

    // register settings per random phase: dist, angle, scale, max lin, max turn, timeout
    longint phase_cfg [6][6] = '{
        '{131072, 1430, 3277, 2048, 2048, 3},
        '{0, 0, 65535, 32767, 32767, 0},
        '{2147483647, 25736, 0, 0, 0, 8190},
        '{65536, 4000, 40000, 8000, 12000, 1},
        '{20000, 300, 1, 32767, 100, 6},
        '{1000000, 12000, 65535, 1000, 32767, 2}
    };
    int phase_idle [6][2] = '{'{0, 0}, '{48, 0}, '{0, 48}, '{37, 37}, '{0, 0}, '{37, 37}};

    initial begin
        i_rst_n = 1'b0;
        s_valid = 1'b0; s_user = '0; s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        errors = 0; send_idle_pct = 0; recv_stall_pct = 0;
        hold_req = 0; hold_done = 0; hold_left = 0;
        dist_th = 131072; angle_th = 1430; scale = 3277;
        max_lin = 2048; max_turn = 2048; timeout = 6000;
        goal_x = 0; goal_y = 0; goal_hdg = 0; goal_set = 0; pose_fresh = 0;
        ticks_since = TICK_MAX;
        last_gx = 0; last_gy = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: stale watchdog, no goal, reached, rotate, translate, steer, extremes
        pending_items.push_back(mk(KIND_TICK, 0, 0, 0, 16384));
        pending_items.push_back(mk(KIND_POSE, 0, 0, 0, 16384));
        pending_items.push_back(mk(KIND_TICK, 0, 0, 0, 16384));
        pending_items.push_back(mk(KIND_POSE, 5, 5, 0, 16384));
        pending_items.push_back(mk(KIND_GOAL, 65536, 65536, 0, 16384));
        pending_items.push_back(mk(KIND_POSE, 65536, 65536, 0, 16384));
        pending_items.push_back(mk(KIND_POSE, 0, 0, 11585, 11585));
        pending_items.push_back(mk(KIND_POSE, -3000000, 800000, 0, 16384));
        pending_items.push_back(mk(KIND_POSE, 9000000, -700000, 16384, 0));
        pending_items.push_back(mk(KIND_POSE, 9000000, -700000, -16384, 0));
        pending_items.push_back(mk(2'd3, -1, -1, -1, -1));
        pending_items.push_back(mk(KIND_GOAL, 64'sd2147483647, -64'sd2147483648, -16384, 16384));
        pending_items.push_back(mk(KIND_POSE, -64'sd2147483648, 64'sd2147483647, 16384, -16384));
        pending_items.push_back(mk(KIND_POSE, 64'sd2147483647, -64'sd2147483648, 0, -16384));
        pending_items.push_back('{KIND_POSE, 32'h80000000, 32'h7FFFFFFF,
                                  16'hC000, 16'h4000, 16'hC000, 16'h4000});
        pending_items.push_back('{KIND_GOAL, 32'h0, 32'h0, 16'h4000, 16'hC000, 16'h4000, 16'hC000});
        pending_items.push_back(mk(KIND_POSE, 0, 0, 0, 0));
        pending_items.push_back(mk(KIND_POSE, 3, -4, 0, -16384));
        drain();

        // random phases, each with its own register setting and idling mix
        for (int p = 0; p < 6; p++) begin
            for (int r = 0; r < 6; r++) write_reg(t_cfg_idx'(r), phase_cfg[p][r]);
            send_idle_pct  = phase_idle[p][0];
            recv_stall_pct = phase_idle[p][1];
            for (int n = 0; n < 190; ) begin
                item_t it;
                it = rand_item();
                pending_items.push_back(it);
                if (it.kind != 2'd3) n++;
            end
            // long receiver hold-off while the sender keeps offering
            if (p == 0 || p == 4) begin
                repeat (200) @(posedge i_clk);
                hold_req++;
            end
            drain();
        end

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog on the whole run
    initial begin
        #40000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
rtl/ggvc_pkg.sv
rtl/ggvc_cordic.sv
rtl/ggvc_dp.sv
rtl/ggvc_ctrl.sv
rtl/go_to_goal_velocity_controller.sv
sim/go_to_goal_velocity_controller_tb.sv
